// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eq3_pkg.sv =====
// ----------------------------------------------------------------------------
// eq3_pkg
// Widths, register indexes, operation codes and shared types of the
// three-band equalizer.
// ----------------------------------------------------------------------------
package eq3_pkg;

    localparam int POLE_FRAC_BITS  = 16;
    localparam int COEFF_FRAC_BITS = 16;
    localparam int GAIN_FRAC_BITS  = 14;

    localparam int SAMPLE_W = 16;
    localparam int POLE_W   = 32;
    localparam int COEFF_W  = 18;
    localparam int GAIN_W   = 16;
    localparam int X_W      = SAMPLE_W + POLE_FRAC_BITS;
    localparam int WIDE_W   = (X_W > POLE_W) ? X_W : POLE_W;
    localparam int DIFF_W   = WIDE_W + 1;
    localparam int MB_W     = COEFF_W + 1;
    localparam int PROD_W   = DIFF_W + MB_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int ACC_W    = PROD_W + 2;
    localparam int OUT_SHIFT = POLE_FRAC_BITS + GAIN_FRAC_BITS;

    localparam int CFG_DATA_W = COEFF_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_COEFF  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEFF = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN  = CFG_IDX_W'(4);

    localparam logic [COEFF_W-1:0] LOW_COEFF_RST  = COEFF_W'(8213);
    localparam logic [COEFF_W-1:0] HIGH_COEFF_RST = COEFF_W'(46092);
    localparam logic [GAIN_W-1:0]  GAIN_RST       = GAIN_W'(16384);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] POLE_STEPS     = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_LOW_GAIN  = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_MID_GAIN  = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_HIGH_GAIN = STEP_W'(10);
    localparam logic [STEP_W-1:0] LAST_STEP      = STEP_W'(11);

    typedef enum logic [2:0] {
        OP_LOW_POLE,
        OP_HIGH_POLE,
        OP_LOW_GAIN,
        OP_MID_GAIN,
        OP_HIGH_GAIN
    } op_t;

    typedef struct packed {
        logic load_sample;
        logic issue;
        op_t  op;
        logic first;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [COEFF_W-1:0] low_coeff;
        logic [COEFF_W-1:0] high_coeff;
        logic [GAIN_W-1:0]  low_gain;
        logic [GAIN_W-1:0]  mid_gain;
        logic [GAIN_W-1:0]  high_gain;
    } cfg_t;

endpackage

// ===== src/eq3_cfg.sv =====
// ----------------------------------------------------------------------------
// eq3_cfg
// Configuration registers: cutoff coefficients and band gains.
// ----------------------------------------------------------------------------
module eq3_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [eq3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [eq3_pkg::CFG_DATA_W-1:0]    cfg_data,
    output eq3_pkg::cfg_t                     cfg
);

    eq3_pkg::cfg_t cfg_reg;
    eq3_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                eq3_pkg::REG_LOW_COEFF: begin
                    cfg_next.low_coeff = cfg_data[eq3_pkg::COEFF_W-1:0];
                end
                eq3_pkg::REG_HIGH_COEFF: begin
                    cfg_next.high_coeff = cfg_data[eq3_pkg::COEFF_W-1:0];
                end
                eq3_pkg::REG_LOW_GAIN: begin
                    cfg_next.low_gain = cfg_data[eq3_pkg::GAIN_W-1:0];
                end
                eq3_pkg::REG_MID_GAIN: begin
                    cfg_next.mid_gain = cfg_data[eq3_pkg::GAIN_W-1:0];
                end
                eq3_pkg::REG_HIGH_GAIN: begin
                    cfg_next.high_gain = cfg_data[eq3_pkg::GAIN_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_coeff  <= eq3_pkg::LOW_COEFF_RST;
            cfg_reg.high_coeff <= eq3_pkg::HIGH_COEFF_RST;
            cfg_reg.low_gain   <= eq3_pkg::GAIN_RST;
            cfg_reg.mid_gain   <= eq3_pkg::GAIN_RST;
            cfg_reg.high_gain  <= eq3_pkg::GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/eq3_ctrl.sv =====
// ----------------------------------------------------------------------------
// eq3_ctrl
// Sequencer that steps the shared multiplier through the pole updates and
// band gains of one item and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eq3_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           m_ready,
    output logic           m_valid,
    output eq3_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [eq3_pkg::STEP_W-1:0]      cnt_reg;
    logic [eq3_pkg::STEP_W-1:0]      cnt_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;

    always_comb begin
        cmd             = '0;
        cmd.op          = eq3_pkg::OP_LOW_POLE;
        cmd.load_sample = s_valid && (state_reg == ST_IDLE);
        cmd.load_out    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        if (state_reg == ST_CALC) begin
            if (cnt_reg < eq3_pkg::POLE_STEPS) begin
                cmd.issue = 1'b1;
                cmd.op    = cnt_reg[0] ? eq3_pkg::OP_HIGH_POLE : eq3_pkg::OP_LOW_POLE;
                cmd.first = (cnt_reg[2:1] == 2'd0);
            end else begin
                unique case (cnt_reg)
                    eq3_pkg::STEP_LOW_GAIN: begin
                        cmd.issue = 1'b1;
                        cmd.op    = eq3_pkg::OP_LOW_GAIN;
                    end
                    eq3_pkg::STEP_MID_GAIN: begin
                        cmd.issue = 1'b1;
                        cmd.op    = eq3_pkg::OP_MID_GAIN;
                    end
                    eq3_pkg::STEP_HIGH_GAIN: begin
                        cmd.issue = 1'b1;
                        cmd.op    = eq3_pkg::OP_HIGH_GAIN;
                    end
                    default: begin
                        cmd.issue = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load_sample) begin
                    state_next = ST_CALC;
                    cnt_next   = '0;
                end
            end
            ST_CALC: begin
                if (cnt_reg == eq3_pkg::LAST_STEP) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (cmd.load_out) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `ASSERT_NEXT(a_accept_starts, s_valid && s_ready, state_reg == ST_CALC, "accept did not start")
    `ASSERT_IMPLY(a_cnt_range, state_reg == ST_CALC, cnt_reg <= eq3_pkg::LAST_STEP, "step overrun")
    `ASSERT_IMPLY(a_valid_source, $rose(m_valid_reg), $past(cmd.load_out), "result without load")

endmodule

// ===== src/eq3_dp.sv =====
// ----------------------------------------------------------------------------
// eq3_dp
// Datapath: pole registers of both cascades, the input delay line, one shared
// multiplier with a registered product, the band accumulator and the output
// register with truncation and saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eq3_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  eq3_pkg::cmd_t                         cmd,
    input  eq3_pkg::cfg_t                         cfg,
    input  logic signed [eq3_pkg::SAMPLE_W-1:0]   sample_in,
    output logic signed [eq3_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                                  clipped
);

    localparam int SAMPLE_W  = eq3_pkg::SAMPLE_W;
    localparam int POLE_W    = eq3_pkg::POLE_W;
    localparam int X_W       = eq3_pkg::X_W;
    localparam int DIFF_W    = eq3_pkg::DIFF_W;
    localparam int MB_W      = eq3_pkg::MB_W;
    localparam int PROD_W    = eq3_pkg::PROD_W;
    localparam int SUM_W     = eq3_pkg::SUM_W;
    localparam int ACC_W     = eq3_pkg::ACC_W;
    localparam int OUT_SHIFT = eq3_pkg::OUT_SHIFT;

    localparam logic signed [SUM_W-1:0] POLE_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] POLE_MIN = SUM_W'(-64'sh8000_0000);
    localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN    = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) <<< OUT_SHIFT) - ACC_W'(1);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] delay_reg [3];
    logic signed [POLE_W-1:0]   lp_reg [4];
    logic signed [POLE_W-1:0]   hp_reg [4];
    logic signed [PROD_W-1:0]   prod_reg;
    eq3_pkg::op_t               tag_op_reg;
    logic                       tag_valid_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       clip_reg;

    logic signed [X_W-1:0]      x_wide;
    logic signed [X_W-1:0]      d3_wide;
    logic signed [DIFF_W-1:0]   mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   product;
    logic signed [PROD_W-1:0]   delta;
    logic signed [SUM_W-1:0]    pole_sum;
    logic signed [POLE_W-1:0]   pole_new;
    logic signed [ACC_W-1:0]    bias_sum;
    logic signed [ACC_W-1:0]    y_full;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       y_clip;

    assign x_wide  = X_W'(x_reg) <<< eq3_pkg::POLE_FRAC_BITS;
    assign d3_wide = X_W'(delay_reg[2]) <<< eq3_pkg::POLE_FRAC_BITS;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            eq3_pkg::OP_LOW_POLE: begin
                mul_a = (cmd.first ? DIFF_W'(x_wide) : DIFF_W'(lp_reg[3]))
                        - DIFF_W'(lp_reg[0]);
                mul_b = signed'(MB_W'(cfg.low_coeff));
            end
            eq3_pkg::OP_HIGH_POLE: begin
                mul_a = (cmd.first ? DIFF_W'(x_wide) : DIFF_W'(hp_reg[3]))
                        - DIFF_W'(hp_reg[0]);
                mul_b = signed'(MB_W'(cfg.high_coeff));
            end
            eq3_pkg::OP_LOW_GAIN: begin
                mul_a = DIFF_W'(lp_reg[3]);
                mul_b = signed'(MB_W'(cfg.low_gain));
            end
            eq3_pkg::OP_MID_GAIN: begin
                mul_a = DIFF_W'(hp_reg[3]) - DIFF_W'(lp_reg[3]);
                mul_b = signed'(MB_W'(cfg.mid_gain));
            end
            eq3_pkg::OP_HIGH_GAIN: begin
                mul_a = DIFF_W'(d3_wide) - DIFF_W'(hp_reg[3]);
                mul_b = signed'(MB_W'(cfg.high_gain));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Pole update from the registered product, saturated to 32 bits.
    always_comb begin
        delta    = prod_reg >>> eq3_pkg::COEFF_FRAC_BITS;
        pole_sum = (tag_op_reg == eq3_pkg::OP_HIGH_POLE) ? SUM_W'(hp_reg[0])
                                                         : SUM_W'(lp_reg[0]);
        pole_sum = pole_sum + SUM_W'(delta);
        if (pole_sum > POLE_MAX) begin
            pole_new = POLE_W'(POLE_MAX);
        end else if (pole_sum < POLE_MIN) begin
            pole_new = POLE_W'(POLE_MIN);
        end else begin
            pole_new = pole_sum[POLE_W-1:0];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (tag_valid_reg) begin
            case (tag_op_reg) inside
                eq3_pkg::OP_LOW_GAIN: begin
                    acc_next = ACC_W'(prod_reg);
                end
                eq3_pkg::OP_MID_GAIN, eq3_pkg::OP_HIGH_GAIN: begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    // Truncation toward zero, then saturation to the sample range.
    always_comb begin
        bias_sum = acc_reg + (acc_reg[ACC_W-1] ? TRUNC_BIAS : '0);
        y_full   = bias_sum >>> OUT_SHIFT;
        y_clip   = 1'b0;
        if (y_full > Y_MAX) begin
            y_sat  = SAMPLE_W'(Y_MAX);
            y_clip = 1'b1;
        end else if (y_full < Y_MIN) begin
            y_sat  = SAMPLE_W'(Y_MIN);
            y_clip = 1'b1;
        end else begin
            y_sat = y_full[SAMPLE_W-1:0];
        end
    end

    // Each retired stage rotates its cascade, so the stage in work always
    // sits at the head and the stage just finished at the tail.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                lp_reg[i] <= '0;
                hp_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                delay_reg[i] <= '0;
            end
        end else begin
            tag_valid_reg <= cmd.issue;
            if (tag_valid_reg && (tag_op_reg == eq3_pkg::OP_LOW_POLE)) begin
                lp_reg[0] <= lp_reg[1];
                lp_reg[1] <= lp_reg[2];
                lp_reg[2] <= lp_reg[3];
                lp_reg[3] <= pole_new;
            end
            if (tag_valid_reg && (tag_op_reg == eq3_pkg::OP_HIGH_POLE)) begin
                hp_reg[0] <= hp_reg[1];
                hp_reg[1] <= hp_reg[2];
                hp_reg[2] <= hp_reg[3];
                hp_reg[3] <= pole_new;
            end
            if (cmd.load_out) begin
                delay_reg[2] <= delay_reg[1];
                delay_reg[1] <= delay_reg[0];
                delay_reg[0] <= x_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            x_reg <= sample_in;
        end
        if (cmd.issue) begin
            prod_reg   <= product;
            tag_op_reg <= cmd.op;
        end
        acc_reg <= acc_next;
        if (cmd.load_out) begin
            sample_out_reg <= y_sat;
            clip_reg       <= y_clip;
        end
    end

    assign sample_out = sample_out_reg;
    assign clipped    = clip_reg;

    `ASSERT_NEXT(a_issue_tagged, cmd.issue, tag_valid_reg, "product not tagged")
    `ASSERT_IMPLY(a_no_overlap, cmd.load_out, !tag_valid_reg && !cmd.issue, "output mid-calculation")

endmodule

// ===== src/three_band_equalizer.sv =====
// ----------------------------------------------------------------------------
// three_band_equalizer
// Three-band audio equalizer built from two four-stage one-pole cascades.
// ----------------------------------------------------------------------------
// One item is one signed 16-bit sample in and one saturated sample out with a
// clip flag. All products go through a single shared multiplier: eight pole
// updates (low and high cascades interleaved) and three band gains, one product
// per cycle. After the calculation the result is loaded into the output
// register once any previous result is taken, and only then does the
// block return to idle. A new item is accepted only while the block is idle,
// and the output register holds the result until it is taken. Configuration
// registers reset to their default coefficients and unity gains.
// ----------------------------------------------------------------------------
module three_band_equalizer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [eq3_pkg::SAMPLE_W-1:0]   s_sample_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [eq3_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic                                  m_clipped,
    input  logic                                  cfg_we,
    input  logic [eq3_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [eq3_pkg::CFG_DATA_W-1:0]        cfg_data
);

    eq3_pkg::cmd_t cmd;
    eq3_pkg::cfg_t cfg;

    eq3_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    eq3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    eq3_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_in  (s_sample_in),
        .sample_out (m_sample_out),
        .clipped    (m_clipped)
    );

endmodule

// ===== test/three_band_equalizer_tb.sv =====
// ----------------------------------------------------------------------------
// three_band_equalizer_tb
// Self-checking testbench for the three-band equalizer. Samples are streamed
// through the block with random idle bursts on both sides. A fixed-point
// predictor tracks the two pole cascades, the input delay line and the
// registers; each returned item is compared with the oldest expected item.
// Directed samples and register extremes come first, then random register
// settings with random streams, then a back-to-back stream at reset values.
// ----------------------------------------------------------------------------
module three_band_equalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eq3_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 105;
    localparam int STREAM_ITEMS   = 150;

    localparam int CAS_LOW   = 0;
    localparam int CAS_HIGH  = 1;
    localparam int BAND_LOW  = 0;
    localparam int BAND_MID  = 1;
    localparam int BAND_HIGH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam longint OUT_MAX = 32767;
    localparam longint OUT_MIN = -32768;
    localparam longint POLE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint POLE_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } eq_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_W-1:0]    s_sample_in = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]    m_sample_out;
    logic                          m_clipped;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    eq_result_t                    expected_q[$];
    int                            fail_count = 0;
    int                            stall_cycles = 0;
    bit                            src_idle_on = 1'b1;
    bit                            sink_idle_on = 1'b1;
    logic signed [SAMPLE_W-1:0]    last_sample = '0;

    longint                        pole_state[2][4];
    longint                        sample_hist[3];
    longint                        cascade_coeff[2];
    longint                        band_gain[3];

    three_band_equalizer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function void reset_equalizer_state();
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < 4; i++) begin
                pole_state[c][i] = 0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            sample_hist[i] = 0;
        end
        cascade_coeff[CAS_LOW]  = longint'(LOW_COEFF_RST);
        cascade_coeff[CAS_HIGH] = longint'(HIGH_COEFF_RST);
        band_gain[BAND_LOW]  = longint'(GAIN_RST);
        band_gain[BAND_MID]  = longint'(GAIN_RST);
        band_gain[BAND_HIGH] = longint'(GAIN_RST);
    endfunction

    function automatic longint clamp_pole(input longint v);
        if (v > POLE_MAX) begin
            return POLE_MAX;
        end
        if (v < POLE_MIN) begin
            return POLE_MIN;
        end
        return v;
    endfunction

    function void equalize(input logic signed [SAMPLE_W-1:0] smp, output eq_result_t res);
        longint x;
        longint stage_in;
        longint delta;
        longint lo;
        longint mid;
        longint hi;
        longint acc;
        longint y;
        x = longint'(smp) <<< POLE_FRAC_BITS;
        for (int c = 0; c < 2; c++) begin
            stage_in = x;
            for (int i = 0; i < 4; i++) begin
                delta = (cascade_coeff[c] * (stage_in - pole_state[c][i])) >>> COEFF_FRAC_BITS;
                pole_state[c][i] = clamp_pole(pole_state[c][i] + delta);
                stage_in = pole_state[c][i];
            end
        end
        lo  = pole_state[CAS_LOW][3];
        hi  = (sample_hist[2] <<< POLE_FRAC_BITS) - pole_state[CAS_HIGH][3];
        mid = pole_state[CAS_HIGH][3] - lo;
        acc = lo * band_gain[BAND_LOW] + mid * band_gain[BAND_MID] + hi * band_gain[BAND_HIGH];
        if (acc >= 0) begin
            y = acc >>> (POLE_FRAC_BITS + GAIN_FRAC_BITS);
        end else begin
            y = -((-acc) >>> (POLE_FRAC_BITS + GAIN_FRAC_BITS));
        end
        res.clip = 1'b0;
        if (y > OUT_MAX) begin
            y = OUT_MAX;
            res.clip = 1'b1;
        end else if (y < OUT_MIN) begin
            y = OUT_MIN;
            res.clip = 1'b1;
        end
        res.sample = SAMPLE_W'(y);
        sample_hist[2] = sample_hist[1];
        sample_hist[1] = sample_hist[0];
        sample_hist[0] = longint'(smp);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        eq_result_t res;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        equalize(smp, res);
        expected_q.push_back(res);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LOW_COEFF:  cascade_coeff[CAS_LOW]  = longint'(data);
            REG_HIGH_COEFF: cascade_coeff[CAS_HIGH] = longint'(data);
            REG_LOW_GAIN:   band_gain[BAND_LOW]  = longint'(data[GAIN_W-1:0]);
            REG_MID_GAIN:   band_gain[BAND_MID]  = longint'(data[GAIN_W-1:0]);
            REG_HIGH_GAIN:  band_gain[BAND_HIGH] = longint'(data[GAIN_W-1:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_DATA_W'(131072);
            2: return '1;
            3: return CFG_DATA_W'($urandom_range(50, 20000));
            4: return CFG_DATA_W'($urandom_range(20000, 131072));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_DATA_W'(GAIN_RST);
            2: return CFG_DATA_W'(16'hFFFF);
            3: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function logic signed [SAMPLE_W-1:0] next_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: last_sample = SAMPLE_W'($urandom);
            3, 4: begin
                v = int'($urandom_range(0, 2000)) - 1000;
                last_sample = SAMPLE_W'(v);
            end
            5: last_sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            6: last_sample = -last_sample;
            default: ;
        endcase
        return last_sample;
    endfunction

    task automatic apply_random_config();
        write_reg(REG_LOW_COEFF, pick_coeff());
        write_reg(REG_HIGH_COEFF, pick_coeff());
        write_reg(REG_LOW_GAIN, pick_gain());
        write_reg(REG_MID_GAIN, pick_gain());
        write_reg(REG_HIGH_GAIN, pick_gain());
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd12345);
        send_sample(-16'sd12345);
    endtask

    // Coefficients beyond 2.0 make the poles overshoot into saturation, and
    // writes to unused indexes must leave every register untouched.
    task automatic test_config_extremes();
        wait_drained();
        write_reg(REG_LOW_COEFF, '1);
        write_reg(REG_HIGH_COEFF, '0);
        write_reg(REG_LOW_GAIN, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_MID_GAIN, '0);
        write_reg(REG_HIGH_GAIN, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, CFG_DATA_W'(18'h15555));
        repeat (3) send_sample(SAMPLE_MAX);
        repeat (3) send_sample(SAMPLE_MIN);
        repeat (2) send_sample(16'sd0);
        wait_drained();
        write_reg(REG_LOW_COEFF, '0);
        write_reg(REG_HIGH_COEFF, CFG_DATA_W'(131072));
        write_reg(REG_LOW_GAIN, '0);
        write_reg(REG_MID_GAIN, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_HIGH_GAIN, '0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(16'sd0);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            apply_random_config();
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) send_sample(next_sample());
        end
    endtask

    task automatic test_back_to_back();
        wait_drained();
        write_reg(REG_LOW_COEFF, CFG_DATA_W'(LOW_COEFF_RST));
        write_reg(REG_HIGH_COEFF, CFG_DATA_W'(HIGH_COEFF_RST));
        write_reg(REG_LOW_GAIN, CFG_DATA_W'(GAIN_RST));
        write_reg(REG_MID_GAIN, CFG_DATA_W'(GAIN_RST));
        write_reg(REG_HIGH_GAIN, CFG_DATA_W'(GAIN_RST));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (STREAM_ITEMS) send_sample(next_sample());
    endtask

    always begin
        @(posedge aclk);
        if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    always @(posedge aclk) begin : check_results
        eq_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                fail_count++;
                $error("unexpected item: sample_out %0d, clipped %0b",
                       m_sample_out, m_clipped);
            end else begin
                want = expected_q.pop_front();
                if (m_sample_out !== want.sample) begin
                    fail_count++;
                    $error("sample_out: expected %0d, actual %0d",
                           want.sample, m_sample_out);
                end
                if (m_clipped !== want.clip) begin
                    fail_count++;
                    $error("clipped: expected %0b, actual %0b", want.clip, m_clipped);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        reset_equalizer_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_random_settings();
        test_back_to_back();
        wait_drained();
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
